// ===== hdl/lpbd_pkg.sv =====
package lpbd_pkg;

  // Largest number of bytes a batch may hold before it is rejected as too long.
  localparam logic [15:0] MAX_BATCH_BYTES = 16'd65535;

  typedef enum logic [2:0] {
    PH_LEN_LO = 3'b001,
    PH_LEN_HI = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_ZERO    = 3'd1,
    ERR_OVERRUN = 3'd2,
    ERR_DANGLE  = 3'd3,
    ERR_TOOLONG = 3'd4
  } err_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  length_low;
    logic [15:0] current_length;
    logic [15:0] remaining;
    logic [15:0] byte_count;
    err_t        first_error;
  } state_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        entry_first;
    logic        entry_final;
    logic [15:0] entry_length;
    logic        batch_done;
    logic        batch_ok;
    err_t        error_code;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:          PH_LEN_LO,
    length_low:     8'd0,
    current_length: 16'd0,
    remaining:      16'd0,
    byte_count:     16'd0,
    first_error:    ERR_NONE
  };

endpackage

// ===== hdl/lpbd_step.sv =====
module lpbd_step (
  input  lpbd_pkg::state_t  cur,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output lpbd_pkg::state_t  nxt,
  output lpbd_pkg::result_t res
);

  logic [15:0] len;
  logic [15:0] rem_dec;

  assign len     = {data_byte, cur.length_low};
  assign rem_dec = (cur.remaining != 16'd0) ? (cur.remaining - 16'd1) : 16'd0;

  always_comb begin
    lpbd_pkg::state_t  st;
    lpbd_pkg::result_t r;
    st = cur;
    r  = '{
      payload_byte:  8'd0,
      payload_valid: 1'b0,
      entry_first:   1'b0,
      entry_final:   1'b0,
      entry_length:  16'd0,
      batch_done:    1'b0,
      batch_ok:      1'b0,
      error_code:    lpbd_pkg::ERR_NONE
    };

    // Once an error is latched every byte up to the final one is swallowed.
    if (cur.first_error == lpbd_pkg::ERR_NONE) begin
      if (cur.byte_count >= lpbd_pkg::MAX_BATCH_BYTES) begin
        st.first_error = lpbd_pkg::ERR_TOOLONG;
      end else begin
        st.byte_count = cur.byte_count + 16'd1;
        case (cur.phase)
          lpbd_pkg::PH_LEN_HI: begin
            if (len == 16'd0) begin
              st.first_error = lpbd_pkg::ERR_ZERO;
            end else begin
              st.current_length = len;
              st.remaining      = len;
              st.phase          = lpbd_pkg::PH_BODY;
              if (last_byte) begin
                st.first_error = lpbd_pkg::ERR_OVERRUN;
              end
            end
          end
          lpbd_pkg::PH_BODY: begin
            r.payload_byte  = data_byte;
            r.payload_valid = 1'b1;
            r.entry_first   = (cur.remaining == cur.current_length);
            r.entry_final   = (cur.remaining <= 16'd1);
            r.entry_length  = cur.current_length;
            st.remaining    = rem_dec;
            if (rem_dec == 16'd0) begin
              st.phase = lpbd_pkg::PH_LEN_LO;
            end else if (last_byte) begin
              st.first_error = lpbd_pkg::ERR_OVERRUN;
            end
          end
          default: begin
            st.length_low = data_byte;
            st.phase      = lpbd_pkg::PH_LEN_HI;
            if (last_byte) begin
              st.first_error = lpbd_pkg::ERR_DANGLE;
            end
          end
        endcase
      end
    end

    if (last_byte) begin
      r.batch_done = 1'b1;
      r.error_code = st.first_error;
      r.batch_ok   = (st.first_error == lpbd_pkg::ERR_NONE);
      st           = lpbd_pkg::STATE_RESET;
    end

    nxt = st;
    res = r;
  end

endmodule

// ===== hdl/length_prefixed_batch_deframer.sv =====
// Length-prefixed batch deframer.
// The input channel (in_valid/in_ready) carries one batch byte per transfer,
// with last_byte set on the final byte of the batch. The batch is a chain of
// entries, each a 16-bit little-endian length followed by that many bytes.
// The output channel (out_valid/out_ready) carries exactly one result per
// input byte: a payload byte with entry marks and length, or an empty result
// for length bytes, and on the final byte the batch verdict and error code.
// The result for a byte is loaded into the result register at the edge that
// accepts it. Throughput is one byte per cycle unless the receiver stalls,
// set by the single result register; the framing logic between state and result
// is one step. When the receiver stalls, the result register holds and in_ready
// drops until the result is taken; in_ready is high again in the cycle it goes.
// Reset clears the framing state and empties the result register; in_ready
// is low while rst is high. All framing state also returns to its reset
// value after each final byte, whatever the verdict.
module length_prefixed_batch_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  payload_byte,
  output logic        payload_valid,
  output logic        entry_first,
  output logic        entry_final,
  output logic [15:0] entry_length,
  output logic        batch_done,
  output logic        batch_ok,
  output logic [2:0]  error_code
);

  lpbd_pkg::state_t  st;
  lpbd_pkg::state_t  st_next;
  lpbd_pkg::result_t res;
  lpbd_pkg::result_t res_next;
  logic              accept;

  assign in_ready = !rst && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  lpbd_step u_step (
    .cur       (st),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .nxt       (st_next),
    .res       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= lpbd_pkg::STATE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign payload_byte  = res.payload_byte;
  assign payload_valid = res.payload_valid;
  assign entry_first   = res.entry_first;
  assign entry_final   = res.entry_final;
  assign entry_length  = res.entry_length;
  assign batch_done    = res.batch_done;
  assign batch_ok      = res.batch_ok;
  assign error_code    = res.error_code;

  // A verdict of success never carries an error code.
  a_ok_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && batch_ok |-> batch_done && (error_code == lpbd_pkg::ERR_NONE))
    else $error("batch_ok given without a clean verdict");

  // Error codes appear only with the verdict.
  a_code_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !batch_done |-> (error_code == lpbd_pkg::ERR_NONE) && !batch_ok)
    else $error("error code outside the verdict");

  // A payload byte always belongs to an entry of non-zero length.
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_valid |-> (entry_length != 16'd0))
    else $error("payload byte with zero entry length");

  // After the final byte every piece of framing state is back at reset.
  a_end_reset: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> (st == lpbd_pkg::STATE_RESET))
    else $error("framing state not cleared after final byte");

  // Once an error is latched, no payload leaves until the batch ends.
  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    accept && (st.first_error != lpbd_pkg::ERR_NONE) |=> !payload_valid)
    else $error("payload emitted after a latched error");

endmodule

// ===== dv/tb_length_prefixed_batch_deframer.sv =====
module tb_length_prefixed_batch_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // Tracks the framing of the batch in flight and holds the results still owed.
  class deframe_scoreboard;
    lpbd_pkg::phase_t  frame_phase;
    logic [7:0]        len_low;
    logic [15:0]       entry_len;
    logic [15:0]       bytes_left;
    logic [15:0]       batch_bytes;
    lpbd_pkg::err_t    latched_err;

    lpbd_pkg::result_t owed_results[$];
    int unsigned       failures;
    int unsigned       framed_bytes;
    int unsigned       payload_seen;
    int unsigned       results_checked;
    int unsigned       verdicts[5];

    function new();
      restart_batch();
    endfunction

    function void restart_batch();
      frame_phase = lpbd_pkg::PH_LEN_LO;
      len_low     = 8'd0;
      entry_len   = 16'd0;
      bytes_left  = 16'd0;
      batch_bytes = 16'd0;
      latched_err = lpbd_pkg::ERR_NONE;
    endfunction

    function void accept_byte(logic [7:0] b, logic last);
      lpbd_pkg::result_t r;
      logic [15:0]       len;
      r = '0;
      r.error_code = lpbd_pkg::ERR_NONE;
      if (latched_err == lpbd_pkg::ERR_NONE) begin
        framed_bytes++;
        if (batch_bytes >= lpbd_pkg::MAX_BATCH_BYTES) begin
          latched_err = lpbd_pkg::ERR_TOOLONG;
        end else begin
          batch_bytes++;
          case (frame_phase)
            lpbd_pkg::PH_LEN_HI: begin
              len = {b, len_low};
              if (len == 16'd0) begin
                latched_err = lpbd_pkg::ERR_ZERO;
              end else begin
                entry_len   = len;
                bytes_left  = len;
                frame_phase = lpbd_pkg::PH_BODY;
                if (last) latched_err = lpbd_pkg::ERR_OVERRUN;
              end
            end
            lpbd_pkg::PH_BODY: begin
              r.payload_byte  = b;
              r.payload_valid = 1'b1;
              r.entry_first   = (bytes_left == entry_len);
              r.entry_final   = (bytes_left <= 16'd1);
              r.entry_length  = entry_len;
              if (bytes_left > 16'd0) bytes_left--;
              if (bytes_left == 16'd0) frame_phase = lpbd_pkg::PH_LEN_LO;
              else if (last) latched_err = lpbd_pkg::ERR_OVERRUN;
            end
            default: begin
              len_low     = b;
              frame_phase = lpbd_pkg::PH_LEN_HI;
              if (last) latched_err = lpbd_pkg::ERR_DANGLE;
            end
          endcase
        end
      end
      if (last) begin
        r.batch_done = 1'b1;
        r.batch_ok   = (latched_err == lpbd_pkg::ERR_NONE);
        r.error_code = latched_err;
        verdicts[latched_err]++;
        restart_batch();
      end
      owed_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
      if (seen !== want) begin
        failures++;
        $error("%s: expected %0d, actual %0d", name, want, seen);
      end
    endfunction

    function void check_result(lpbd_pkg::result_t got);
      lpbd_pkg::result_t want;
      if (owed_results.size() == 0) begin
        failures++;
        $error("result transfer arrived with no byte outstanding");
        return;
      end
      want = owed_results.pop_front();
      results_checked++;
      if (want.payload_valid) payload_seen++;
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("payload_valid", want.payload_valid, got.payload_valid);
      compare_field("entry_first", want.entry_first, got.entry_first);
      compare_field("entry_final", want.entry_final, got.entry_final);
      compare_field("entry_length", want.entry_length, got.entry_length);
      compare_field("batch_done", want.batch_done, got.batch_done);
      compare_field("batch_ok", want.batch_ok, got.batch_ok);
      compare_field("error_code", want.error_code, got.error_code);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        entry_first;
  logic        entry_final;
  logic [15:0] entry_length;
  logic        batch_done;
  logic        batch_ok;
  logic [2:0]  error_code;

  deframe_scoreboard sb;
  logic [8:0]        batch_q[$];  // {last, data}
  bit                idle_on = 1'b0;
  int unsigned       ready_burst = 0;
  int unsigned       cycle_count = 0;
  int unsigned       stop_at;

  length_prefixed_batch_deframer uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_byte  (payload_byte),
    .payload_valid (payload_valid),
    .entry_first   (entry_first),
    .entry_final   (entry_final),
    .entry_length  (entry_length),
    .batch_done    (batch_done),
    .batch_ok      (batch_ok),
    .error_code    (error_code)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** length_prefixed_batch_deframer: FAILED **");
      $finish;
    end
  end

  // Result side: checks each transfer and stalls the receiver in short bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result(lpbd_pkg::result_t'({payload_byte, payload_valid, entry_first,
                                             entry_final, entry_length, batch_done,
                                             batch_ok, error_code}));
      if (ready_burst > 0) begin
        ready_burst--;
      end else if (idle_on && out_ready && $urandom_range(0, 2) == 0) begin
        out_ready   <= 1'b0;
        ready_burst = $urandom_range(1, 9) - 1;
      end else begin
        out_ready   <= 1'b1;
        ready_burst = $urandom_range(0, 15);
      end
    end
  end

  // Valid is left high between back-to-back bytes and dropped only for a gap.
  task automatic send_byte(logic [8:0] item);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= item[7:0];
    last_byte <= item[8];
    do @(posedge clk); while (!in_ready);
    sb.accept_byte(item[7:0], item[8]);
  endtask

  task automatic send_batch();
    batch_q[batch_q.size() - 1][8] = 1'b1;
    foreach (batch_q[i]) send_byte(batch_q[i]);
    batch_q.delete();
  endtask

  function automatic void add_entry(int unsigned len);
    batch_q.push_back({1'b0, len[7:0]});
    batch_q.push_back({1'b0, len[15:8]});
    repeat (len) batch_q.push_back({1'b0, 8'($urandom)});
  endfunction

  // Mostly short entries, now and then one whose length needs the high byte.
  function automatic int unsigned pick_length();
    case ($urandom_range(0, 19))
      0:       return $urandom_range(256, 300);
      1, 2, 3: return $urandom_range(9, 40);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  task automatic random_batch();
    int unsigned kind;
    int unsigned cut;
    kind = $urandom_range(0, 9);
    if (kind == 8) begin
      repeat ($urandom_range(1, 12)) batch_q.push_back({1'b0, 8'($urandom)});
    end else begin
      repeat ($urandom_range(1, 4)) add_entry(pick_length());
      if (kind == 7) begin
        add_entry(0);
        if ($urandom_range(0, 1) == 1) add_entry(pick_length());
      end
      if (kind == 9) batch_q.push_back({1'b0, 8'($urandom)});
      if (kind == 6) begin
        cut = $urandom_range(1, batch_q.size());
        while (batch_q.size() > cut) void'(batch_q.pop_back());
      end
    end
    send_batch();
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    // Two good entries, one of a single byte, with the byte value extremes.
    batch_q = '{9'h001, 9'h000, 9'h0FF, 9'h002, 9'h000, 9'h000, 9'h0A5};
    send_batch();
    // A zero-length entry on the final byte, then one followed by a swallowed byte.
    batch_q = '{9'h000, 9'h000};
    send_batch();
    batch_q = '{9'h000, 9'h000, 9'h055};
    send_batch();
    // A batch that stops on a lone low length byte.
    batch_q = '{9'h005};
    send_batch();
    // Batches that end inside an entry: on its high length byte, then in its payload.
    batch_q = '{9'h003, 9'h000};
    send_batch();
    batch_q = '{9'h003, 9'h000, 9'h011, 9'h022};
    send_batch();
    batch_q = '{9'h0FF, 9'h080};
    send_batch();

    while (sb.framed_bytes < 340) random_batch();

    // The closing stretch runs with no gaps on the input side.
    idle_on = 1'b0;
    stop_at = sb.framed_bytes + 60;
    while (sb.framed_bytes < stop_at) random_batch();

    in_valid <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d result transfers, %0d of them payload bytes.",
             sb.results_checked, sb.payload_seen);
    $display("Batch verdicts: %0d clean, %0d zero entry, %0d overrun, %0d dangling, %0d oversize.",
             sb.verdicts[lpbd_pkg::ERR_NONE], sb.verdicts[lpbd_pkg::ERR_ZERO],
             sb.verdicts[lpbd_pkg::ERR_OVERRUN], sb.verdicts[lpbd_pkg::ERR_DANGLE],
             sb.verdicts[lpbd_pkg::ERR_TOOLONG]);
    if (sb.failures == 0 && sb.owed_results.size() == 0) begin
      $display("** length_prefixed_batch_deframer: PASSED **");
    end else begin
      $display("** length_prefixed_batch_deframer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lpbd_pkg.sv
hdl/lpbd_step.sv
hdl/length_prefixed_batch_deframer.sv
dv/tb_length_prefixed_batch_deframer.sv
